FILE: src/m3i_pkg.sv
package m3i_pkg;

    localparam int DIM      = 3;
    localparam int NUM_ELEM = DIM * DIM;
    localparam int FIELD_W  = 32;
    localparam int IN_W     = NUM_ELEM * FIELD_W;
    localparam int OUT_W    = NUM_ELEM * FIELD_W;

    typedef struct packed {
        logic zero;
        logic neg;
    } det_flags_t;

    typedef struct packed {
        logic singular;
        logic overflow;
    } lane_flags_t;

endpackage

FILE: src/m3i_cof_lane.sv
module m3i_cof_lane #(
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                en_prod,
    input  logic                en_diff,
    input  logic signed [W-1:0] a_in,
    input  logic signed [W-1:0] b_in,
    input  logic signed [W-1:0] c_in,
    input  logic signed [W-1:0] d_in,
    output logic signed [2*W:0] cof
);

    logic signed [2*W-1:0] p1_reg, p2_reg;
    logic signed [2*W-1:0] p1_next, p2_next;
    logic signed [2*W:0]   cof_reg, cof_next;

    assign p1_next  = a_in * b_in;
    assign p2_next  = c_in * d_in;
    assign cof_next = (2*W+1)'(p1_reg) - (2*W+1)'(p2_reg);

    always_ff @(posedge aclk) begin
        if (en_prod) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (en_diff) begin
            cof_reg <= cof_next;
        end
    end

    assign cof = cof_reg;

endmodule

FILE: src/m3i_det.sv
module m3i_det #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic [4:0]            en,
    input  logic signed [W-1:0]   a0 [m3i_pkg::DIM],
    input  logic signed [2*W:0]   cof0 [m3i_pkg::DIM],
    output logic [3*W:0]          dmag,
    output m3i_pkg::det_flags_t   dflags
);

    localparam int DETW = 3 * W + 2;
    localparam int DMW  = 3 * W + 1;

    logic signed [W-1:0]  a_d1_reg [m3i_pkg::DIM];
    logic signed [W-1:0]  a_d2_reg [m3i_pkg::DIM];
    logic signed [2*W:0]  plo_reg  [m3i_pkg::DIM];
    logic signed [2*W:0]  phi_reg  [m3i_pkg::DIM];
    logic signed [DETW-1:0] det_reg, det_next;
    logic [DMW-1:0]       dmag_reg, dmag_next;
    m3i_pkg::det_flags_t  dflags_reg, dflags_next;

    always_comb begin
        det_next = '0;
        for (int j = 0; j < m3i_pkg::DIM; j++) begin
            det_next = det_next + (DETW'(phi_reg[j]) <<< W) + DETW'(plo_reg[j]);
        end
    end

    always_comb begin
        dflags_next.neg  = det_reg[DETW-1];
        dflags_next.zero = (det_reg == '0);
        dmag_next = det_reg[DETW-1] ? DMW'(-det_reg) : DMW'(det_reg);
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < m3i_pkg::DIM; j++) begin
            if (en[0]) begin
                a_d1_reg[j] <= a0[j];
            end
            if (en[1]) begin
                a_d2_reg[j] <= a_d1_reg[j];
            end
            if (en[2]) begin
                plo_reg[j] <= a_d2_reg[j] * $signed({1'b0, cof0[j][W-1:0]});
                phi_reg[j] <= a_d2_reg[j] * $signed(cof0[j][2*W:W]);
            end
        end
        if (en[3]) begin
            det_reg <= det_next;
        end
        if (en[4]) begin
            dmag_reg   <= dmag_next;
            dflags_reg <= dflags_next;
        end
    end

    assign dmag   = dmag_reg;
    assign dflags = dflags_reg;

endmodule

FILE: src/m3i_div_lane.sv
module m3i_div_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                 aclk,
    input  logic [W+3:0]         en,
    input  logic signed [2*W:0]  cof,
    input  logic [3*W:0]         dmag,
    input  m3i_pkg::det_flags_t  dflags,
    output logic [W-1:0]         res,
    output m3i_pkg::lane_flags_t flags
);

    localparam int DMW = 3 * W + 1;
    localparam int NMW = 2 * W + 2 * F;
    localparam int CW  = ((NMW > DMW + W) ? NMW : DMW + W) + 1;

    logic signed [2*W:0] c1_reg, c2_reg;
    logic [NMW-1:0]      nmag_reg, nmag_next;
    logic                nneg_reg;
    logic [CW-1:0]       r_reg   [W+1];
    logic [DMW-1:0]      d_reg   [W+1];
    logic [W-1:0]        q_reg   [W+1];
    logic                neg_reg [W+1];
    logic                sat_reg [W+1];
    logic                zero_reg [W+1];
    logic [2*W-1:0]      cabs;
    logic [W-1:0]        qf;
    logic                neg_eff, over;

    assign cabs      = c2_reg[2*W] ? (2*W)'(-c2_reg) : (2*W)'(c2_reg);
    assign nmag_next = NMW'(cabs) << (2 * F);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            c1_reg <= cof;
        end
        if (en[1]) begin
            c2_reg <= c1_reg;
        end
        if (en[2]) begin
            nmag_reg <= nmag_next;
            nneg_reg <= c2_reg[2*W];
        end
        if (en[3]) begin
            r_reg[0]    <= CW'(nmag_reg);
            d_reg[0]    <= dmag;
            q_reg[0]    <= '0;
            sat_reg[0]  <= CW'(nmag_reg) >= (CW'(dmag) << W);
            neg_reg[0]  <= nneg_reg ^ dflags.neg;
            zero_reg[0] <= dflags.zero;
        end
    end

    for (genvar s = 1; s <= W; s++) begin : g_step
        localparam int B = W - s;
        logic [CW-1:0] sub;
        logic          take;

        assign sub  = CW'(d_reg[s-1]) << B;
        assign take = r_reg[s-1] >= sub;

        always_ff @(posedge aclk) begin
            if (en[3+s]) begin
                r_reg[s]    <= take ? r_reg[s-1] - sub : r_reg[s-1];
                q_reg[s]    <= q_reg[s-1] | (take ? (W'(1) << B) : '0);
                d_reg[s]    <= d_reg[s-1];
                sat_reg[s]  <= sat_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    assign qf      = q_reg[W];
    assign neg_eff = neg_reg[W] && (sat_reg[W] || (qf != '0));

    always_comb begin
        over = sat_reg[W] ||
               (neg_eff ? ({1'b0, qf} > ((W+1)'(1) << (W - 1)))
                        : ({1'b0, qf} > (((W+1)'(1) << (W - 1)) - (W+1)'(1))));
        if (zero_reg[W]) begin
            res = '0;
        end else if (over) begin
            res = neg_eff ? (W'(1) << (W - 1)) : ~(W'(1) << (W - 1));
        end else begin
            res = neg_eff ? -qf : qf;
        end
        flags.singular = zero_reg[W];
        flags.overflow = over && !zero_reg[W];
    end

endmodule

FILE: src/matrix3x3_inverse.sv
// Inverse of a signed fixed-point 3x3 matrix by the adjugate. Each transfer on
// s_ carries nine elements in Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS; each transfer on
// m_ returns the nine inverse elements, truncated toward zero and saturated,
// with a singular flag (zero determinant, all elements zero) and an overflow
// flag (some element saturated). A new matrix is taken every cycle unless
// m_tready low holds the pipe back. The nine divider lanes resolve one
// quotient bit per pipeline stage. The pipe only holds where a stage is
// occupied and the next one cannot move.
module matrix3x3_inverse #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, ... elem_r2c2, 32 bits each
    input  logic [m3i_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, ... inv_r2c2, 32 bits each
    output logic [m3i_pkg::OUT_W-1:0]  m_tdata,
    // singular, overflow
    output logic [1:0]                 m_tuser
);

    localparam int W  = DATA_WIDTH;
    localparam int IW = (W > m3i_pkg::FIELD_W) ? W : m3i_pkg::FIELD_W;
    localparam int NS = W + 7;

    logic [NS-1:0]  v_reg;
    logic [NS:0]    rdy;
    logic [NS-1:0]  en;

    logic signed [W-1:0] a   [m3i_pkg::NUM_ELEM];
    logic signed [2*W:0] cof [m3i_pkg::NUM_ELEM];
    logic signed [W-1:0] a0  [m3i_pkg::DIM];
    logic signed [2*W:0] cof0 [m3i_pkg::DIM];
    logic [3*W:0]         dmag;
    m3i_pkg::det_flags_t  dflags;
    logic [W-1:0]         res [m3i_pkg::NUM_ELEM];
    m3i_pkg::lane_flags_t lflags [m3i_pkg::NUM_ELEM];

    logic [W-1:0]  out_reg [m3i_pkg::NUM_ELEM];
    logic          sing_reg, ovf_reg, ovf_next;

    always_comb begin
        rdy[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign en       = rdy[NS-1:0];
    assign s_tready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (en[i]) begin
                    v_reg[i] <= (i == 0) ? s_tvalid : v_reg[i-1];
                end
            end
        end
    end

    for (genvar k = 0; k < m3i_pkg::NUM_ELEM; k++) begin : g_unpack
        logic [IW-1:0] ext;
        assign ext  = IW'(s_tdata[k*m3i_pkg::FIELD_W +: m3i_pkg::FIELD_W]);
        assign a[k] = $signed(ext[W-1:0]);
    end

    for (genvar i = 0; i < m3i_pkg::DIM; i++) begin : g_row
        for (genvar j = 0; j < m3i_pkg::DIM; j++) begin : g_col
            localparam int R1 = (i + 1) % m3i_pkg::DIM;
            localparam int R2 = (i + 2) % m3i_pkg::DIM;
            localparam int C1 = (j + 1) % m3i_pkg::DIM;
            localparam int C2 = (j + 2) % m3i_pkg::DIM;

            m3i_cof_lane #(.W(W)) u_cof (
                .aclk    (aclk),
                .en_prod (en[0]),
                .en_diff (en[1]),
                .a_in    (a[R1*m3i_pkg::DIM + C1]),
                .b_in    (a[R2*m3i_pkg::DIM + C2]),
                .c_in    (a[R1*m3i_pkg::DIM + C2]),
                .d_in    (a[R2*m3i_pkg::DIM + C1]),
                .cof     (cof[i*m3i_pkg::DIM + j])
            );

            m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_div (
                .aclk   (aclk),
                .en     (en[W+5:2]),
                .cof    (cof[j*m3i_pkg::DIM + i]),
                .dmag   (dmag),
                .dflags (dflags),
                .res    (res[i*m3i_pkg::DIM + j]),
                .flags  (lflags[i*m3i_pkg::DIM + j])
            );
        end
        assign a0[i]   = a[i];
        assign cof0[i] = cof[i];
    end

    m3i_det #(.W(W)) u_det (
        .aclk   (aclk),
        .en     (en[4:0]),
        .a0     (a0),
        .cof0   (cof0),
        .dmag   (dmag),
        .dflags (dflags)
    );

    always_comb begin
        ovf_next = 1'b0;
        for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
            ovf_next = ovf_next | lflags[k].overflow;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NS-1]) begin
            for (int k = 0; k < m3i_pkg::NUM_ELEM; k++) begin
                out_reg[k] <= res[k];
            end
            sing_reg <= lflags[0].singular;
            ovf_reg  <= ovf_next;
        end
    end

    for (genvar k = 0; k < m3i_pkg::NUM_ELEM; k++) begin : g_pack
        assign m_tdata[k*m3i_pkg::FIELD_W +: m3i_pkg::FIELD_W] =
            m3i_pkg::FIELD_W'(out_reg[k]);
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tuser  = {ovf_reg, sing_reg};

    a_sing_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1])
        else $error("singular result also flagged overflow");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("singular result carries nonzero elements");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    a_pipe_move: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v_reg[0])
        else $error("accepted transfer did not enter the pipeline");

endmodule
